>>> rtl/alm_pkg.sv
// Shared constants, codes and fixed-point helpers for the audio level meter.
package alm_pkg;

    // Operation codes carried in the request's tuser field
    typedef enum logic [2:0] {
        OP_PEAK = 3'd0,
        OP_RMS  = 3'd1,
        OP_BAND = 3'd2,
        OP_FADE = 3'd3,
        OP_TICK = 3'd4
    } t_op;

    // Configuration register indexes
    localparam logic [1:0] REG_CLIP_THR   = 2'd0;
    localparam logic [1:0] REG_SIG_THR    = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS = 2'd2;

    // Register reset values
    localparam logic [15:0] CLIP_THR_RST   = 16'd64880;
    localparam logic [15:0] SIG_THR_RST    = 16'd328;
    localparam logic [15:0] HOLD_TICKS_RST = 16'd1000;

    // Decay factors, unsigned Q0.16 (0.990 and 0.999)
    localparam logic [15:0] DECAY_FAST = 16'd64881;
    localparam logic [15:0] DECAY_SLOW = 16'd65470;

    // dB levels, signed Q8.8
    localparam logic signed [15:0] DB_FLOOR    = -16'sd25600;
    localparam logic signed [15:0] DB_CEIL     = 16'sd0;
    localparam logic signed [15:0] FRAME_FLOOR = -16'sd15360;
    localparam logic signed [17:0] DB_OFFSET   = 18'sd15360;
    localparam logic signed [17:0] S16_MIN     = -18'sd32768;
    localparam logic signed [17:0] S16_MAX     = 18'sd32767;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // Level shifted up by 60 dB so the decay pulls towards -60 dB
    function automatic logic signed [17:0] db_shift(input logic signed [15:0] v);
        db_shift = 18'(v) + DB_OFFSET;
    endfunction

    // Magnitude of the shifted level
    function automatic logic [16:0] db_mag(input logic signed [17:0] t);
        logic signed [17:0] a;
        a = t[17] ? -t : t;
        db_mag = a[16:0];
    endfunction

    // Re-apply sign, shift back down by 60 dB and saturate to 16 bits
    function automatic logic signed [15:0] db_restore(input logic neg, input logic [16:0] q);
        logic signed [17:0] s;
        logic signed [17:0] r;
        s = $signed({1'b0, q});
        if (neg) begin
            s = -s;
        end
        r = s - DB_OFFSET;
        if (r < S16_MIN) begin
            db_restore = 16'sh8000;
        end else if (r > S16_MAX) begin
            db_restore = 16'sh7FFF;
        end else begin
            db_restore = r[15:0];
        end
    endfunction

endpackage

>>> rtl/audio_level_meter_with_hold.sv
// Audio level meter: peak and RMS metering with hold, per-band levels and fade.
//
//  Channel   Direction  Signals                         Contents (lowest bit first)
//  s_axis    in         tvalid tready tdata[39:0] tuser  level, band_index, band_level;
//                                                       tuser = operation
//  m_axis    out        tvalid tready tdata[103:0]       peak_now, peak_smoothed, peak_held,
//                                                       clip_flag, signal_present,
//                                                       band_smoothed, band_held,
//                                                       loudest_band, loudest_level
//  cfg       in         we addr[1:0] wdata[15:0]         clip / signal threshold, hold ticks
//
//  Peak, RMS, band and tick requests pass from acceptance to the next acceptance through
//  one memory read, one read-modify-write and the load of the output register.
//  A fade request first decays the peak levels, then sweeps the band memory one entry per cycle
//  through the two decay multipliers, reading the next entry while the current one is written.
//  Reset is synchronous; per-entry valid bits make unwritten bands read as -100 dB, so no
//  clearing pass is needed. A request is taken while an earlier result still waits on m_axis;
//  its result is held back until the output register is free.
module audio_level_meter_with_hold
    import alm_pkg::*;
#(
    parameter int NUM_BANDS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [15:0] level, [19:16] band_index, [35:20] band_level, [39:36] zero
    input  logic [39:0]  i_s_axis_tdata,
    // [2:0] operation
    input  logic [2:0]   i_s_axis_tuser,

    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] peak_now, [31:16] peak_smoothed, [47:32] peak_held, [48] clip_flag,
    // [49] signal_present, [65:50] band_smoothed, [81:66] band_held,
    // [85:82] loudest_band, [100:86] loudest_level, [103:101] zero
    output logic [103:0] o_m_axis_tdata,

    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata
);

    localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam logic [6:0]    NB7      = 7'(NUM_BANDS);
    localparam logic [AW-1:0] LAST_ENT = AW'(NUM_BANDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_PEAK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [15:0] r_clip_thr, r_sig_thr, r_hold_ticks;

    // Scalar meter state
    logic [15:0]        r_last_peak, n_last_peak;
    logic [15:0]        r_smooth_peak, n_smooth_peak;
    logic [15:0]        r_hold_peak, n_hold_peak;
    logic               r_clip, n_clip;
    logic               r_sig, n_sig;
    logic [15:0]        r_ticks, n_ticks;
    logic signed [15:0] r_fmax_lvl, n_fmax_lvl;
    logic [3:0]         r_fmax_idx, n_fmax_idx;

    // Captured request
    logic [2:0]         r_op, n_op;
    logic [15:0]        r_level, n_level;
    logic [3:0]         r_bi, n_bi;
    logic signed [15:0] r_bl, n_bl;

    // Sweep counter and band result
    logic [AW-1:0]      r_cnt, n_cnt;
    logic signed [15:0] r_res_smooth, n_res_smooth;
    logic signed [15:0] r_res_hold, n_res_hold;

    // Output register
    logic               r_out_vld, n_out_vld;
    logic [103:0]       r_out_data, n_out_data;

    // Band memory: {hold, smooth} per entry, valid bits per entry
    logic [31:0]          mem [NUM_BANDS];
    logic [NUM_BANDS-1:0] r_valid;
    logic [31:0]          r_rd_data;
    logic                 r_rd_vld;

    logic [6:0]    w_raddr_ext;
    logic [AW-1:0] w_raddr;
    logic          w_rd_ok;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    logic               w_accept;
    logic [6:0]         w_bi_ext;
    logic [AW-1:0]      w_bi_addr;
    logic               w_in_rng;
    logic signed [15:0] w_cur_smooth, w_cur_hold;
    logic signed [15:0] w_bl_clamped;
    logic signed [15:0] w_new_smooth, w_new_hold;
    logic signed [15:0] w_base_lvl;
    logic [3:0]         w_base_idx;

    // Decay datapath
    logic signed [17:0] w_ts_smooth, w_ts_hold;
    logic [16:0]        w_fa, w_sa;
    logic [32:0]        w_pf, w_ps;
    logic signed [15:0] w_dec_smooth, w_dec_hold;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // Band address of the captured request
    assign w_bi_ext  = 7'(r_bi);
    assign w_bi_addr = w_bi_ext[AW-1:0];
    assign w_in_rng  = (w_bi_ext < NB7);

    // Read address: requested band on acceptance, entry 0 before a sweep, next entry in it
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr_ext = 7'(i_s_axis_tdata[19:16]);
            S_SWEEP: w_raddr_ext = 7'(r_cnt) + 7'd1;
            default: w_raddr_ext = 7'd0;
        endcase
    end
    assign w_raddr = w_raddr_ext[AW-1:0];
    assign w_rd_ok = (w_raddr_ext < NB7);

    // Unwritten entries read as -100 dB
    assign w_cur_smooth = r_rd_vld ? $signed(r_rd_data[15:0])  : DB_FLOOR;
    assign w_cur_hold   = r_rd_vld ? $signed(r_rd_data[31:16]) : DB_FLOOR;

    // Band level clamped to [-100 dB, 0 dB]
    always_comb begin
        if (r_bl < DB_FLOOR) begin
            w_bl_clamped = DB_FLOOR;
        end else if (r_bl > DB_CEIL) begin
            w_bl_clamped = DB_CEIL;
        end else begin
            w_bl_clamped = r_bl;
        end
    end
    assign w_new_smooth = (w_bl_clamped > w_cur_smooth) ? w_bl_clamped : w_cur_smooth;
    assign w_new_hold   = (w_bl_clamped > w_cur_hold)   ? w_bl_clamped : w_cur_hold;

    // Band zero opens a new frame
    assign w_base_lvl = (r_bi == 4'd0) ? FRAME_FLOOR : r_fmax_lvl;
    assign w_base_idx = (r_bi == 4'd0) ? 4'd0 : r_fmax_idx;

    // Two constant multipliers shared by peak decay and band sweep
    assign w_ts_smooth = db_shift(w_cur_smooth);
    assign w_ts_hold   = db_shift(w_cur_hold);
    assign w_fa = (r_state == S_PEAK) ? {1'b0, r_smooth_peak} : db_mag(w_ts_smooth);
    assign w_sa = (r_state == S_PEAK) ? {1'b0, r_hold_peak}   : db_mag(w_ts_hold);
    assign w_pf = 33'(w_fa) * 33'(DECAY_FAST);
    assign w_ps = 33'(w_sa) * 33'(DECAY_SLOW);
    assign w_dec_smooth = db_restore(w_ts_smooth[17], w_pf[32:16]);
    assign w_dec_hold   = db_restore(w_ts_hold[17], w_ps[32:16]);

    // Next-state and datapath
    always_comb begin
        n_state       = r_state;
        n_last_peak   = r_last_peak;
        n_smooth_peak = r_smooth_peak;
        n_hold_peak   = r_hold_peak;
        n_clip        = r_clip;
        n_sig         = r_sig;
        n_ticks       = r_ticks;
        n_fmax_lvl    = r_fmax_lvl;
        n_fmax_idx    = r_fmax_idx;
        n_op          = r_op;
        n_level       = r_level;
        n_bi          = r_bi;
        n_bl          = r_bl;
        n_cnt         = r_cnt;
        n_res_smooth  = r_res_smooth;
        n_res_hold    = r_res_hold;
        n_out_vld     = r_out_vld;
        n_out_data    = r_out_data;
        w_we          = 1'b0;
        w_waddr       = w_bi_addr;
        w_wdata       = {w_new_hold, w_new_smooth};

        // Output register drains independently
        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_s_axis_tuser;
                    n_level = i_s_axis_tdata[15:0];
                    n_bi    = i_s_axis_tdata[19:16];
                    n_bl    = $signed(i_s_axis_tdata[35:20]);
                    n_state = (i_s_axis_tuser == OP_FADE) ? S_PEAK : S_UPD;
                end
            end

            S_UPD: begin
                n_res_smooth = w_in_rng ? w_cur_smooth : DB_FLOOR;
                n_res_hold   = w_in_rng ? w_cur_hold   : DB_FLOOR;
                unique case (r_op)
                    OP_PEAK: begin
                        n_last_peak = r_level;
                        if (r_level > r_smooth_peak) n_smooth_peak = r_level;
                        if (r_level > r_hold_peak)   n_hold_peak   = r_level;
                        n_clip = (r_level > r_clip_thr);
                    end
                    OP_RMS: begin
                        if (r_ticks > r_hold_ticks) n_sig = 1'b0;
                        if (r_level > r_sig_thr) begin
                            n_sig   = 1'b1;
                            n_ticks = '0;
                        end
                    end
                    OP_BAND: begin
                        if (w_in_rng) begin
                            w_we         = 1'b1;
                            n_res_smooth = w_new_smooth;
                            n_res_hold   = w_new_hold;
                            if (w_bl_clamped > w_base_lvl) begin
                                n_fmax_lvl = w_bl_clamped;
                                n_fmax_idx = r_bi;
                            end else begin
                                n_fmax_lvl = w_base_lvl;
                                n_fmax_idx = w_base_idx;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (r_ticks != TICKS_MAX) n_ticks = r_ticks + 16'd1;
                    end
                    default: begin
                        // unused codes leave the state alone
                    end
                endcase
                n_state = S_DONE;
            end

            S_PEAK: begin
                n_smooth_peak = w_pf[31:16];
                n_hold_peak   = w_ps[31:16];
                n_res_smooth  = DB_FLOOR;
                n_res_hold    = DB_FLOOR;
                n_cnt         = '0;
                n_state       = S_SWEEP;
            end

            S_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = {w_dec_hold, w_dec_smooth};
                if (w_in_rng && (r_cnt == w_bi_addr)) begin
                    n_res_smooth = w_dec_smooth;
                    n_res_hold   = w_dec_hold;
                end
                if (r_cnt == LAST_ENT) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end

            S_DONE: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {3'b000, r_fmax_lvl[14:0], r_fmax_idx,
                                  r_res_hold, r_res_smooth, r_sig, r_clip,
                                  r_hold_peak, r_smooth_peak, r_last_peak};
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State, meter registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_clip_thr    <= CLIP_THR_RST;
            r_sig_thr     <= SIG_THR_RST;
            r_hold_ticks  <= HOLD_TICKS_RST;
            r_last_peak   <= '0;
            r_smooth_peak <= '0;
            r_hold_peak   <= '0;
            r_clip        <= 1'b0;
            r_sig         <= 1'b0;
            r_ticks       <= '0;
            r_fmax_lvl    <= FRAME_FLOOR;
            r_fmax_idx    <= '0;
            r_cnt         <= '0;
            r_out_vld     <= 1'b0;
            r_valid       <= '0;
        end else begin
            r_state       <= n_state;
            r_last_peak   <= n_last_peak;
            r_smooth_peak <= n_smooth_peak;
            r_hold_peak   <= n_hold_peak;
            r_clip        <= n_clip;
            r_sig         <= n_sig;
            r_ticks       <= n_ticks;
            r_fmax_lvl    <= n_fmax_lvl;
            r_fmax_idx    <= n_fmax_idx;
            r_cnt         <= n_cnt;
            r_out_vld     <= n_out_vld;
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_CLIP_THR:   r_clip_thr   <= i_cfg_wdata;
                    REG_SIG_THR:    r_sig_thr    <= i_cfg_wdata;
                    REG_HOLD_TICKS: r_hold_ticks <= i_cfg_wdata;
                    default: begin
                        // index beyond the register list: ignored
                    end
                endcase
            end
        end
        // payload
        r_op         <= n_op;
        r_level      <= n_level;
        r_bi         <= n_bi;
        r_bl         <= n_bl;
        r_res_smooth <= n_res_smooth;
        r_res_hold   <= n_res_hold;
        r_out_data   <= n_out_data;
    end

    // Band memory: one write and one registered read per cycle; a sweep reads entry k+1
    // while writing entry k, and other requests write in the update state, before the next request's read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_ok) begin
            r_rd_data <= mem[w_raddr];
        end
        r_rd_vld <= w_rd_ok && r_valid[w_raddr];
    end

`ifndef SYNTHESIS
    // Accepting a request drops tready, so requests are never taken back to back
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("request accepted while previous one in progress");

    // Memory writes stay inside the band table
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (7'(w_waddr) < NB7))
        else $error("band memory write out of range");

    // Loudest level stays within [-60 dB, 0 dB]
    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fmax_lvl >= FRAME_FLOOR) && (r_fmax_lvl <= DB_CEIL))
        else $error("loudest level out of range");

    // A fresh result appears only out of the completion state
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion state");

    // Sweep counter never runs past the last entry
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_cnt <= LAST_ENT))
        else $error("sweep counter out of range");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the audio level meter: stream traffic, predictor and scoreboard.
`timescale 1ns / 100ps

module testbench;
    import alm_pkg::*;

    localparam int BAND_COUNT = 16;
    localparam int OP_CODE_MAX = 7;
    localparam int HALF_PERIOD = 6;
    localparam longint TIMEOUT_NS = 64'd20_000_000;

    // Request layout on the slave-side tdata, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [15:0] band_level;
        logic [3:0]         band_index;
        logic [15:0]        level;
    } t_meter_request;

    // Reading layout on the master-side tdata, lowest field last
    typedef struct packed {
        logic [2:0]         pad;
        logic signed [14:0] loudest_level;
        logic [3:0]         loudest_band;
        logic signed [15:0] band_held;
        logic signed [15:0] band_smoothed;
        logic               signal_present;
        logic               clip_flag;
        logic [15:0]        peak_held;
        logic [15:0]        peak_smoothed;
        logic [15:0]        peak_now;
    } t_meter_reading;

    // Meter predictor plus the queue of readings still owed by the block
    class t_level_meter_scoreboard;
        logic [15:0]        clip_thr = CLIP_THR_RST;
        logic [15:0]        sig_thr = SIG_THR_RST;
        logic [15:0]        hold_ticks = HOLD_TICKS_RST;
        logic [15:0]        last_peak = '0;
        logic [15:0]        smooth_peak = '0;
        logic [15:0]        hold_peak = '0;
        logic               clip_on = 1'b0;
        logic               signal_on = 1'b0;
        logic [15:0]        ticks_quiet = '0;
        logic signed [15:0] band_smooth [BAND_COUNT] = '{default: DB_FLOOR};
        logic signed [15:0] band_hold [BAND_COUNT] = '{default: DB_FLOOR};
        logic signed [15:0] frame_max = FRAME_FLOOR;
        logic [3:0]         frame_max_idx = '0;
        t_meter_reading     readings_due [$];
        int                 mismatches = 0;

        function void write_reg(logic [1:0] addr, logic [15:0] val);
            case (addr)
                REG_CLIP_THR:   clip_thr = val;
                REG_SIG_THR:    sig_thr = val;
                REG_HOLD_TICKS: hold_ticks = val;
                default: ;
            endcase
        endfunction

        // Amplitude decay, product truncated
        function logic [15:0] fade_amplitude(logic [15:0] x, logic [15:0] f);
            logic [31:0] p;
            p = x * f;
            return p[31:16];
        endfunction

        // dB decay about -60 dB, magnitude truncated so it closes in from both sides
        function logic signed [15:0] fade_db(logic signed [15:0] v, logic [15:0] f);
            longint shifted;
            longint mag;
            longint r;
            shifted = longint'(v) + longint'(DB_OFFSET);
            mag = (shifted < 0) ? -shifted : shifted;
            r = (mag * longint'(f)) >>> 16;
            if (shifted < 0) begin
                r = -r;
            end
            r = r - longint'(DB_OFFSET);
            if (r < -32768) begin
                r = -32768;
            end else if (r > 32767) begin
                r = 32767;
            end
            return r[15:0];
        endfunction

        // Advance the predicted state by one accepted request and queue its reading
        function void note_request(logic [2:0] op, logic [15:0] level, logic [3:0] idx,
                                   logic signed [15:0] db_in);
            t_meter_reading want;
            logic signed [15:0] db;
            logic hit;
            db = db_in;
            hit = idx < BAND_COUNT;
            case (op)
                OP_PEAK: begin
                    last_peak = level;
                    if (level > smooth_peak) smooth_peak = level;
                    if (level > hold_peak) hold_peak = level;
                    clip_on = level > clip_thr;
                end
                OP_RMS: begin
                    if (ticks_quiet > hold_ticks) signal_on = 1'b0;
                    if (level > sig_thr) begin
                        signal_on = 1'b1;
                        ticks_quiet = '0;
                    end
                end
                OP_BAND: begin
                    if (db < DB_FLOOR) db = DB_FLOOR;
                    if (db > DB_CEIL) db = DB_CEIL;
                    if (hit) begin
                        if (db > band_smooth[idx]) band_smooth[idx] = db;
                        if (db > band_hold[idx]) band_hold[idx] = db;
                        // band zero opens a new frame
                        if (idx == 0) begin
                            frame_max = FRAME_FLOOR;
                            frame_max_idx = '0;
                        end
                        if (db > frame_max) begin
                            frame_max = db;
                            frame_max_idx = idx;
                        end
                    end
                end
                OP_FADE: begin
                    smooth_peak = fade_amplitude(smooth_peak, DECAY_FAST);
                    hold_peak = fade_amplitude(hold_peak, DECAY_SLOW);
                    foreach (band_smooth[i]) begin
                        band_smooth[i] = fade_db(band_smooth[i], DECAY_FAST);
                        band_hold[i] = fade_db(band_hold[i], DECAY_SLOW);
                    end
                end
                OP_TICK: begin
                    if (ticks_quiet != TICKS_MAX) ticks_quiet = ticks_quiet + 1'b1;
                end
                default: ;
            endcase
            want = '0;
            want.peak_now = last_peak;
            want.peak_smoothed = smooth_peak;
            want.peak_held = hold_peak;
            want.clip_flag = clip_on;
            want.signal_present = signal_on;
            want.band_smoothed = hit ? band_smooth[idx] : DB_FLOOR;
            want.band_held = hit ? band_hold[idx] : DB_FLOOR;
            want.loudest_band = frame_max_idx;
            want.loudest_level = frame_max[14:0];
            readings_due.push_back(want);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted reading with the oldest one owed
        function void check_reading(logic [103:0] raw);
            t_meter_reading got;
            t_meter_reading want;
            got = raw;
            if (readings_due.size() == 0) begin
                $display("%0t: unrequested reading, expected none, got %h", $time, raw);
                mismatches++;
                return;
            end
            want = readings_due.pop_front();
            check_field("peak_now", want.peak_now, got.peak_now);
            check_field("peak_smoothed", want.peak_smoothed, got.peak_smoothed);
            check_field("peak_held", want.peak_held, got.peak_held);
            check_field("clip_flag", want.clip_flag, got.clip_flag);
            check_field("signal_present", want.signal_present, got.signal_present);
            check_field("band_smoothed", want.band_smoothed, got.band_smoothed);
            check_field("band_held", want.band_held, got.band_held);
            check_field("loudest_band", want.loudest_band, got.loudest_band);
            check_field("loudest_level", want.loudest_level, got.loudest_level);
            check_field("padding", want.pad, got.pad);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    // [15:0] level, [19:16] band_index, [35:20] band_level, [39:36] zero
    logic [39:0]  i_s_axis_tdata;
    // [2:0] operation
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    // [15:0] peak_now, [31:16] peak_smoothed, [47:32] peak_held, [48] clip_flag,
    // [49] signal_present, [65:50] band_smoothed, [81:66] band_held,
    // [85:82] loudest_band, [100:86] loudest_level, [103:101] zero
    logic [103:0] o_m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [15:0]  i_cfg_wdata;

    t_level_meter_scoreboard sb = new;
    logic sender_idles = 1'b1;
    logic receiver_stalls = 1'b1;

    audio_level_meter_with_hold #(
        .NUM_BANDS (BAND_COUNT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #HALF_PERIOD;
        i_clk = 1'b1;
        #HALF_PERIOD;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reading side: check each accepted reading, stall in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_reading(o_m_axis_tdata);
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    // Offer one request, with an optional idle burst first; returns once accepted
    task automatic send_request(logic [2:0] op, logic [15:0] level, logic [3:0] idx,
                                logic signed [15:0] db);
        t_meter_request req;
        req = '{pad: '0, band_level: db, band_index: idx, level: level};
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= req;
        i_s_axis_tuser <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, level, idx, db);
    endtask

    // Drain every owed reading, then allow for a fade still sweeping the bands
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.readings_due.size() != 0) @(posedge i_clk);
        repeat (BAND_COUNT + 4) @(posedge i_clk);
    endtask

    // Write all three registers back to back; enable stays high throughout
    task automatic apply_settings(logic [15:0] clip, logic [15:0] sig, logic [15:0] hold);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_CLIP_THR;
        i_cfg_wdata <= clip;
        @(posedge i_clk);
        sb.write_reg(REG_CLIP_THR, clip);
        i_cfg_addr <= REG_SIG_THR;
        i_cfg_wdata <= sig;
        @(posedge i_clk);
        sb.write_reg(REG_SIG_THR, sig);
        i_cfg_addr <= REG_HOLD_TICKS;
        i_cfg_wdata <= hold;
        @(posedge i_clk);
        sb.write_reg(REG_HOLD_TICKS, hold);
        i_cfg_we <= 1'b0;
    endtask

    // Amplitude biased towards a threshold and the extremes
    function automatic logic [15:0] pick_amplitude(logic [15:0] thr);
        case ($urandom_range(0, 7))
            0: return thr - 1'b1;
            1: return thr;
            2: return thr + 1'b1;
            3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Band level: mostly in range, some near the frame floor, some any 16-bit value
    function automatic logic signed [15:0] pick_db();
        int v;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: begin
                v = $urandom_range(0, 4);
                return FRAME_FLOOR + 16'(v) - 16'sd2;
            end
            default: begin
                v = $urandom_range(0, 25600);
                return 16'(-v);
            end
        endcase
    endfunction

    // Edge values, clamping, frame tracking, decay, ticks and unused codes
    task automatic run_directed();
        send_request(OP_PEAK, 16'hFFFF, 4'd0, DB_FLOOR);
        send_request(OP_PEAK, CLIP_THR_RST, 4'd1, DB_CEIL);
        send_request(OP_PEAK, CLIP_THR_RST + 1'b1, 4'd2, DB_FLOOR);
        send_request(OP_PEAK, 16'h0000, 4'd15, DB_FLOOR);
        send_request(OP_RMS, SIG_THR_RST, 4'd0, DB_FLOOR);
        send_request(OP_RMS, SIG_THR_RST + 1'b1, 4'd0, DB_FLOOR);
        send_request(OP_RMS, 16'hFFFF, 4'd0, DB_FLOOR);
        // new frame below the floor, then ties and clamped inputs
        send_request(OP_BAND, 16'h0000, 4'd0, -16'sd20000);
        send_request(OP_BAND, 16'h0000, 4'd1, FRAME_FLOOR);
        send_request(OP_BAND, 16'h0000, 4'd2, FRAME_FLOOR + 1'b1);
        send_request(OP_BAND, 16'h0000, 4'd3, FRAME_FLOOR + 1'b1);
        send_request(OP_BAND, 16'hFFFF, 4'd4, 16'sh7FFF);
        send_request(OP_BAND, 16'h0000, 4'd5, 16'sh8000);
        send_request(OP_BAND, 16'h0000, 4'd15, DB_FLOOR);
        send_request(OP_BAND, 16'h0000, 4'd14, DB_CEIL);
        send_request(OP_FADE, 16'h0000, 4'd4, DB_FLOOR);
        send_request(OP_FADE, 16'h0000, 4'd15, DB_FLOOR);
        send_request(OP_TICK, 16'h0000, 4'd14, DB_FLOOR);
        send_request(OP_RMS, 16'h0000, 4'd2, DB_FLOOR);
        send_request(3'(OP_TICK) + 3'd1, 16'hFFFF, 4'd4, DB_CEIL);
        send_request(3'(OP_CODE_MAX), 16'hFFFF, 4'd0, 16'sh8000);
        send_request(OP_BAND, 16'h0000, 4'd0, DB_FLOOR);
        send_request(OP_PEAK, 16'h0001, 4'd3, DB_FLOOR);
    endtask

    // Mostly well-formed frames and sample traffic, with some noise
    task automatic random_traffic(int count);
        int sent;
        int kind;
        int bands;
        int n;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                bands = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BAND_COUNT) : BAND_COUNT;
                for (int k = 0; k < bands; k++) begin
                    send_request(OP_BAND, 16'($urandom), 4'(k), pick_db());
                end
                sent += bands;
            end else if (kind < 50) begin
                send_request(OP_PEAK, pick_amplitude(sb.clip_thr), 4'($urandom), pick_db());
                sent++;
            end else if (kind < 63) begin
                send_request(OP_RMS, pick_amplitude(sb.sig_thr), 4'($urandom), pick_db());
                sent++;
            end else if (kind < 72) begin
                send_request(OP_FADE, 16'($urandom), 4'($urandom), pick_db());
                sent++;
            end else if (kind < 92) begin
                n = $urandom_range(1, 30);
                repeat (n) send_request(OP_TICK, 16'($urandom), 4'($urandom), pick_db());
                sent += n;
            end else begin
                send_request(3'($urandom_range(0, OP_CODE_MAX)), 16'($urandom),
                             4'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_settings(CLIP_THR_RST, SIG_THR_RST, HOLD_TICKS_RST);
        run_directed();

        // random phases, each under its own settings and idling mix
        for (int phase = 0; phase < 7; phase++) begin
            wait_idle();
            case (phase)
                0: apply_settings(16'h0000, 16'h0000, 16'h0000);
                1: apply_settings(16'hFFFF, 16'hFFFF, TICKS_MAX);
                default: apply_settings(16'($urandom), 16'($urandom_range(0, 4000)),
                                        16'($urandom_range(0, 40)));
            endcase
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            random_traffic(190);
        end

        // no idling from here: signal expiry stepped across the hold boundary
        wait_idle();
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        apply_settings(CLIP_THR_RST, SIG_THR_RST, 16'd20);
        send_request(OP_RMS, 16'hFFFF, 4'($urandom), pick_db());
        for (int k = 0; k < 23; k++) begin
            send_request(OP_TICK, 16'($urandom), 4'($urandom), pick_db());
            send_request(OP_RMS, 16'h0000, 4'($urandom), pick_db());
        end
        // full hold keeps the signal through a few quiet ticks
        wait_idle();
        apply_settings(CLIP_THR_RST, SIG_THR_RST, TICKS_MAX);
        send_request(OP_RMS, 16'hFFFF, 4'($urandom), pick_db());
        repeat (5) send_request(OP_TICK, 16'($urandom), 4'($urandom), pick_db());
        send_request(OP_RMS, 16'h0000, 4'($urandom), pick_db());
        wait_idle();

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
